// ===== design/ddsp_pkg.sv =====
// Shared constants, types and helpers of the dense shortest-path engine.
`default_nettype none
package ddsp_pkg;

    localparam int VERTICES = 16;
    localparam int VIDX_W   = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int ADJ_N    = VERTICES * VERTICES;
    localparam int ADJ_AW   = $clog2(ADJ_N);

    // Field widths of the stream items
    localparam int KIND_W = 2;
    localparam int VTX_FW = 4;
    localparam int WT_W   = 16;
    localparam int DIST_W = 20;
    localparam int CNT_W  = 9;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [DIST_W-1:0] NO_PATH = DIST_W'(999999);

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_INIT,
        ST_SCAN,
        ST_RELAX,
        ST_RELAX_END,
        ST_EMIT
    } state_t;

    function automatic logic [ADJ_AW-1:0] adj_addr(input logic [VTX_FW-1:0] row,
                                                   input logic [VTX_FW-1:0] col);
        adj_addr = ADJ_AW'(int'(row) * VERTICES + int'(col));
    endfunction

    function automatic logic vtx_ok(input logic [VTX_FW-1:0] v);
        vtx_ok = ({1'b0, v} < (VTX_FW+1)'(VERTICES));
    endfunction

endpackage
`default_nettype wire

// ===== design/ddsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ddsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

// ===== design/dense_dijkstra_shortest_paths.sv =====
// Top level of the dense shortest-path engine: edge store, sequencer, result stage.
//
// Usage:
//   Input requests arrive on s_tvalid/s_tready. s_tuser carries the kind: add edge,
//   remove edge, run shortest paths (any other code is a no-op edge request).
//   Edge requests return one result with the updated edge count and m_tlast set.
//   A run request returns one result per vertex, vertex 0 first, m_tlast on the
//   final one; m_tuser flags a reached vertex, unreached ones report 999999.
// Timing:
//   An edge request passes through the EDGE state to the result register. A run
//   passes INIT, then for each reached vertex a scan of the distance registers
//   and a row sweep (RELAX, RELAX_END) through the single read port of the
//   adjacency RAM, then a final scan that finds none, then EMIT, which sends the
//   results in turn as m_tready allows. s_tready is high only while idle.
// Reset:
//   aresetn clears all edges (per-entry valid bits), the edge count and the
//   sequencer; no clearing pass is needed.
// Stall:
//   A stalled m_tready holds the result register; the sequencer waits on it.
`default_nettype none
module dense_dijkstra_shortest_paths (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // from_vertex[3:0], to_vertex[7:4], weight[23:8], source_vertex[27:24], zero pad
    input  wire logic [ddsp_pkg::S_DATA_W-1:0] s_tdata,
    // kind[1:0]
    input  wire logic [ddsp_pkg::KIND_W-1:0]   s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // vertex[3:0], distance[23:4], edge_count[32:24], zero pad
    output logic      [ddsp_pkg::M_DATA_W-1:0] m_tdata,
    // reachable[0]
    output logic      [0:0]                    m_tuser,
    output logic                               m_tlast
);

    localparam logic [ddsp_pkg::VIDX_W-1:0] LAST_V = ddsp_pkg::VIDX_W'(ddsp_pkg::VERTICES - 1);

    ddsp_pkg::state_t state_reg, state_next;

    // Latched request
    logic [ddsp_pkg::KIND_W-1:0] kind_reg;
    logic [ddsp_pkg::VTX_FW-1:0] from_reg, to_reg, src_reg;
    logic [ddsp_pkg::WT_W-1:0]   weight_reg;

    // Graph and search state
    logic [ddsp_pkg::ADJ_N-1:0]  adj_vld_reg;
    logic [ddsp_pkg::CNT_W-1:0]  edge_cnt_reg, edge_cnt_next;
    logic [ddsp_pkg::DIST_W-1:0] dist_reg [ddsp_pkg::VERTICES];
    logic [ddsp_pkg::VERTICES-1:0] done_reg;
    logic [ddsp_pkg::DIST_W-1:0] best_reg, best_next;
    logic [ddsp_pkg::VIDX_W-1:0] pick_reg, pick_next;
    logic [ddsp_pkg::VIDX_W-1:0] cnt_reg, cnt_next;

    // Row sweep read pipeline
    logic                        rd_pend_reg;
    logic                        rd_edge_reg;
    logic [ddsp_pkg::VIDX_W-1:0] rd_idx_reg;
    logic [ddsp_pkg::WT_W-1:0]   rd_wt;

    // Result register
    logic                        m_tvalid_reg;
    logic [ddsp_pkg::VTX_FW-1:0] m_vertex_reg;
    logic [ddsp_pkg::DIST_W-1:0] m_dist_reg;
    logic                        m_reach_reg;
    logic [ddsp_pkg::CNT_W-1:0]  m_count_reg;
    logic                        m_last_reg;

    // Sequencer strobes
    logic in_take, edge_go, emit_go, scan_en, relax_issue, init_en, rescan;
    logic cnt_step, cnt_last, out_free;

    logic                        scan_hit;
    logic                        scan_found;
    logic [ddsp_pkg::ADJ_AW-1:0] edge_addr, rd_addr;
    logic                        edge_present, do_add, do_remove;
    logic [ddsp_pkg::DIST_W:0]   cand;
    logic                        relax_upd;

    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_last = (cnt_reg == LAST_V);

    // Scan: lowest index wins among equal minima
    assign scan_hit   = (dist_reg[cnt_reg] < best_reg) && !done_reg[cnt_reg];
    assign best_next  = scan_hit ? dist_reg[cnt_reg] : best_reg;
    assign pick_next  = scan_hit ? cnt_reg : pick_reg;
    assign scan_found = (best_next != ddsp_pkg::NO_PATH);

    // Edge update
    assign edge_addr    = ddsp_pkg::adj_addr(from_reg, to_reg);
    assign edge_present = adj_vld_reg[edge_addr];
    assign do_add    = edge_go && (kind_reg == ddsp_pkg::KIND_ADD)
                       && ddsp_pkg::vtx_ok(from_reg) && ddsp_pkg::vtx_ok(to_reg)
                       && (weight_reg != '0) && !edge_present;
    assign do_remove = edge_go && (kind_reg == ddsp_pkg::KIND_REMOVE)
                       && ddsp_pkg::vtx_ok(from_reg) && ddsp_pkg::vtx_ok(to_reg)
                       && edge_present;

    always_comb begin
        edge_cnt_next = edge_cnt_reg;
        if (do_add) begin
            edge_cnt_next = edge_cnt_reg + ddsp_pkg::CNT_W'(1);
        end else if (do_remove) begin
            edge_cnt_next = edge_cnt_reg - ddsp_pkg::CNT_W'(1);
        end
    end

    // Relaxation: strict greater-than replaces
    assign rd_addr = ddsp_pkg::adj_addr(ddsp_pkg::VTX_FW'(pick_reg), ddsp_pkg::VTX_FW'(cnt_reg));
    assign cand    = (ddsp_pkg::DIST_W+1)'(best_reg) + (ddsp_pkg::DIST_W+1)'(rd_wt);
    assign relax_upd = rd_pend_reg && rd_edge_reg
                       && ({1'b0, dist_reg[rd_idx_reg]} > cand);

    ddsp_ram #(
        .WIDTH (ddsp_pkg::WT_W),
        .DEPTH (ddsp_pkg::ADJ_N)
    ) u_adj_ram (
        .aclk  (aclk),
        .we    (do_add),
        .waddr (edge_addr),
        .wdata (weight_reg),
        .raddr (rd_addr),
        .rdata (rd_wt)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ddsp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == ddsp_pkg::KIND_RUN) ? ddsp_pkg::ST_INIT
                                                                 : ddsp_pkg::ST_EDGE;
                end
            end
            ddsp_pkg::ST_EDGE: begin
                if (out_free) begin
                    state_next = ddsp_pkg::ST_IDLE;
                end
            end
            ddsp_pkg::ST_INIT: begin
                state_next = ddsp_pkg::ST_SCAN;
            end
            ddsp_pkg::ST_SCAN: begin
                if (cnt_last) begin
                    state_next = scan_found ? ddsp_pkg::ST_RELAX : ddsp_pkg::ST_EMIT;
                end
            end
            ddsp_pkg::ST_RELAX: begin
                if (cnt_last) begin
                    state_next = ddsp_pkg::ST_RELAX_END;
                end
            end
            ddsp_pkg::ST_RELAX_END: begin
                state_next = ddsp_pkg::ST_SCAN;
            end
            ddsp_pkg::ST_EMIT: begin
                if (out_free && cnt_last) begin
                    state_next = ddsp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ddsp_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_take     = 1'b0;
        edge_go     = 1'b0;
        emit_go     = 1'b0;
        scan_en     = 1'b0;
        relax_issue = 1'b0;
        init_en     = 1'b0;
        rescan      = 1'b0;
        unique case (state_reg)
            ddsp_pkg::ST_IDLE:      in_take     = s_tvalid;
            ddsp_pkg::ST_EDGE:      edge_go     = out_free;
            ddsp_pkg::ST_INIT:      init_en     = 1'b1;
            ddsp_pkg::ST_SCAN:      scan_en     = 1'b1;
            ddsp_pkg::ST_RELAX:     relax_issue = 1'b1;
            ddsp_pkg::ST_RELAX_END: rescan      = 1'b1;
            ddsp_pkg::ST_EMIT:      emit_go     = out_free;
            default: begin
            end
        endcase
    end

    assign cnt_step = scan_en || relax_issue || emit_go;

    always_comb begin
        cnt_next = cnt_reg;
        if (init_en || rescan) begin
            cnt_next = '0;
        end else if (cnt_step) begin
            cnt_next = cnt_last ? '0 : cnt_reg + ddsp_pkg::VIDX_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ddsp_pkg::ST_IDLE;
            adj_vld_reg  <= '0;
            edge_cnt_reg <= '0;
            done_reg     <= '0;
            cnt_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            rd_edge_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            edge_cnt_reg <= edge_cnt_next;
            cnt_reg      <= cnt_next;
            rd_pend_reg  <= relax_issue;
            rd_edge_reg  <= relax_issue && adj_vld_reg[rd_addr];
            if (do_add) begin
                adj_vld_reg[edge_addr] <= 1'b1;
            end else if (do_remove) begin
                adj_vld_reg[edge_addr] <= 1'b0;
            end
            if (init_en) begin
                done_reg <= '0;
            end else if (scan_en && cnt_last && scan_found) begin
                done_reg[pick_next] <= 1'b1;
            end
            if (edge_go || emit_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            kind_reg   <= s_tuser;
            from_reg   <= s_tdata[3:0];
            to_reg     <= s_tdata[7:4];
            weight_reg <= s_tdata[23:8];
            src_reg    <= s_tdata[27:24];
        end
        rd_idx_reg <= cnt_reg;
        if (init_en || rescan) begin
            best_reg <= ddsp_pkg::NO_PATH;
            pick_reg <= '0;
        end else if (scan_en) begin
            best_reg <= best_next;
            pick_reg <= pick_next;
        end
        if (init_en) begin
            for (int i = 0; i < ddsp_pkg::VERTICES; i++) begin
                dist_reg[i] <= ddsp_pkg::NO_PATH;
            end
            if (ddsp_pkg::vtx_ok(src_reg)) begin
                dist_reg[src_reg[ddsp_pkg::VIDX_W-1:0]] <= '0;
            end
        end else if (relax_upd) begin
            dist_reg[rd_idx_reg] <= cand[ddsp_pkg::DIST_W-1:0];
        end
        if (edge_go) begin
            m_vertex_reg <= '0;
            m_dist_reg   <= '0;
            m_reach_reg  <= 1'b0;
            m_count_reg  <= edge_cnt_next;
            m_last_reg   <= 1'b1;
        end else if (emit_go) begin
            m_vertex_reg <= ddsp_pkg::VTX_FW'(cnt_reg);
            m_dist_reg   <= dist_reg[cnt_reg];
            m_reach_reg  <= done_reg[cnt_reg];
            m_count_reg  <= edge_cnt_reg;
            m_last_reg   <= cnt_last;
        end
    end

    assign s_tready = (state_reg == ddsp_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_count_reg, m_dist_reg, m_vertex_reg};
    assign m_tuser  = m_reach_reg;
    assign m_tlast  = m_last_reg;

    // A selected vertex is marked done before its row is swept
    a_pick_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ddsp_pkg::ST_SCAN && state_next == ddsp_pkg::ST_RELAX)
        |=> done_reg[pick_reg])
        else $error("picked vertex not marked done");

    // Edge count never exceeds the matrix size
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_cnt_reg <= ddsp_pkg::CNT_W'(ddsp_pkg::ADJ_N))
        else $error("edge count out of range");

    // A reached vertex always reports a real distance
    a_reach_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_reach_reg) |-> (m_dist_reg < ddsp_pkg::NO_PATH))
        else $error("reached vertex reports no path");

    // Read data lines up with the index issued in the previous cycle
    a_rd_align: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (rd_idx_reg == $past(cnt_reg)))
        else $error("row sweep read misaligned");

endmodule
`default_nettype wire

// ===== test/dense_dijkstra_shortest_paths_tb.sv =====
// Self-checking stream testbench for the dense shortest-path engine: edge edits and path runs.
`timescale 1ns / 100ps
module dense_dijkstra_shortest_paths_tb;
    import ddsp_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
    localparam int RANDOM_REQUESTS = 248;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int MAX_PRINTED     = 60;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [S_DATA_W-1:0] data;
    } request_t;

    typedef struct packed {
        logic [VTX_FW-1:0] vertex;
        logic [DIST_W-1:0] distance;
        logic              reachable;
        logic [CNT_W-1:0]  edge_count;
        logic              last;
    } path_result_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // from_vertex[3:0], to_vertex[7:4], weight[23:8], source_vertex[27:24], zero pad
    logic [S_DATA_W-1:0] s_tdata  = '0;
    // kind[1:0]
    logic [KIND_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // vertex[3:0], distance[23:4], edge_count[32:24], zero pad
    logic [M_DATA_W-1:0] m_tdata;
    // reachable[0]
    logic [0:0]          m_tuser;
    logic                m_tlast;

    request_t     pending_requests[$];
    request_t     next_request;
    path_result_t awaited_results[$];

    // shadow of the block's edge store
    logic [WT_W-1:0]  edge_weight [VERTICES][VERTICES] = '{default: '0};
    logic [CNT_W-1:0] edge_tally = '0;

    // occupancy as seen while planning the stimulus
    bit planned_edge [VERTICES][VERTICES];

    int  error_count = 0;
    int  result_index = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  recv_wait = 0;
    bit  send_burst = 1'b0;
    bit  recv_burst = 1'b0;

    dense_dijkstra_shortest_paths dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t: result %0d %0s: got %0d, expected %0d",
                     $time, result_index, what, got, want);
    endtask

    // Random wait per request or result; occasionally flip into or out of a no-wait stretch.
    function automatic int pick_wait(inout bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 7);
    endfunction

    // Update the edge store for one accepted request and queue the results it owes.
    task automatic apply_request(input logic [KIND_W-1:0] kind, input logic [S_DATA_W-1:0] data);
        logic [VTX_FW-1:0] from_v;
        logic [VTX_FW-1:0] to_v;
        logic [VTX_FW-1:0] src;
        logic [WT_W-1:0]   wt;
        int                path_dist [VERTICES];
        bit [VERTICES-1:0] settled;
        int                best;
        int                pick;
        int                cand;
        path_result_t      res;
        from_v = data[3:0];
        to_v   = data[7:4];
        wt     = data[23:8];
        src    = data[27:24];
        if (kind == KIND_RUN) begin
            for (int i = 0; i < VERTICES; i++)
                path_dist[i] = int'(NO_PATH);
            settled   = '0;
            path_dist[src] = 0;
            while (1) begin
                best = int'(NO_PATH);
                pick = 0;
                // lowest index wins among equal minima
                for (int i = 0; i < VERTICES; i++) begin
                    if (path_dist[i] < best && !settled[i]) begin
                        best = path_dist[i];
                        pick = i;
                    end
                end
                if (best == int'(NO_PATH))
                    break;
                settled[pick] = 1'b1;
                for (int i = 0; i < VERTICES; i++) begin
                    if (edge_weight[pick][i] != 0) begin
                        cand = path_dist[pick] + int'(edge_weight[pick][i]);
                        if (path_dist[i] > cand)
                            path_dist[i] = cand;
                    end
                end
            end
            for (int i = 0; i < VERTICES; i++) begin
                res.vertex     = VTX_FW'(i);
                res.distance   = DIST_W'(path_dist[i]);
                res.reachable  = settled[i];
                res.edge_count = edge_tally;
                res.last       = (i == VERTICES - 1);
                awaited_results.push_back(res);
            end
        end else begin
            if (kind == KIND_ADD && wt != 0) begin
                if (edge_weight[from_v][to_v] == 0) begin
                    edge_weight[from_v][to_v] = wt;
                    edge_tally++;
                end
            end else if (kind == KIND_REMOVE) begin
                if (edge_weight[from_v][to_v] != 0) begin
                    edge_weight[from_v][to_v] = '0;
                    edge_tally--;
                end
            end
            res = '{vertex: '0, distance: '0, reachable: 1'b0,
                    edge_count: edge_tally, last: 1'b1};
            awaited_results.push_back(res);
        end
    endtask

    task automatic check_result();
        path_result_t want;
        if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result, vertex", int'(m_tdata[3:0]), -1);
            return;
        end
        want = awaited_results.pop_front();
        if (m_tdata[3:0] !== want.vertex)
            report_mismatch("vertex", int'(m_tdata[3:0]), int'(want.vertex));
        if (m_tdata[23:4] !== want.distance)
            report_mismatch("distance", int'(m_tdata[23:4]), int'(want.distance));
        if (m_tuser[0] !== want.reachable)
            report_mismatch("reachable", int'(m_tuser[0]), int'(want.reachable));
        if (m_tdata[32:24] !== want.edge_count)
            report_mismatch("edge_count", int'(m_tdata[32:24]), int'(want.edge_count));
        if (m_tlast !== want.last)
            report_mismatch("last", int'(m_tlast), int'(want.last));
        result_index++;
    endtask

    task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [VTX_FW-1:0] from_v,
                                 input logic [VTX_FW-1:0] to_v, input logic [WT_W-1:0] wt,
                                 input logic [VTX_FW-1:0] src);
        request_t req;
        req.kind = kind;
        req.data = {4'b0, src, wt, to_v, from_v};
        pending_requests.push_back(req);
        if (kind == KIND_ADD && wt != 0)
            planned_edge[from_v][to_v] = 1'b1;
        else if (kind == KIND_REMOVE)
            planned_edge[from_v][to_v] = 1'b0;
    endtask

    // Driver: hold a request until taken, predict on acceptance, then wait and advance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                apply_request(s_tuser, s_tdata);
            if (send_gap != 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_requests.size() != 0) begin
                next_request = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_request.data;
                s_tuser  <= next_request.kind;
                send_gap <= pick_wait(send_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each result taken, then stall for a random count.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
                recv_wait = pick_wait(recv_burst);
            end else if (recv_wait != 0) begin
                recv_wait = recv_wait - 1;
            end
            m_tready <= (recv_wait == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int                roll;
        int                pool [$];
        int                slot;
        logic [VTX_FW-1:0] from_v;
        logic [VTX_FW-1:0] to_v;
        logic [VTX_FW-1:0] src;
        logic [WT_W-1:0]   wt;

        // empty graph, then zero, full-scale and duplicate adds
        queue_request(KIND_RUN,    4'd0,  4'd0,  16'h0000, 4'd0);
        queue_request(KIND_ADD,    4'd0,  4'd1,  16'h0000, 4'd0);
        queue_request(KIND_ADD,    4'd0,  4'd1,  16'hFFFF, 4'd0);
        queue_request(KIND_ADD,    4'd0,  4'd1,  16'h0007, 4'd0);
        queue_request(KIND_ADD,    4'd0,  4'd2,  16'h0003, 4'd0);
        queue_request(KIND_ADD,    4'd2,  4'd1,  16'h0002, 4'd0);
        queue_request(KIND_ADD,    4'd0,  4'd3,  16'h0005, 4'd0);
        queue_request(KIND_ADD,    4'd3,  4'd15, 16'hAAAA, 4'd0);
        queue_request(KIND_ADD,    4'd15, 4'd14, 16'h5555, 4'd0);
        queue_request(KIND_ADD,    4'd14, 4'd15, 16'h0001, 4'd0);
        queue_request(KIND_ADD,    4'd5,  4'd5,  16'h0009, 4'd0);
        // removal of a missing edge and a no-op kind carrying busy fields
        queue_request(KIND_REMOVE, 4'd7,  4'd8,  16'h0000, 4'd0);
        queue_request(KIND_NOP,    4'd15, 4'd15, 16'hFFFF, 4'd15);
        queue_request(KIND_RUN,    4'd0,  4'd0,  16'h0000, 4'd0);
        queue_request(KIND_REMOVE, 4'd0,  4'd2,  16'h0000, 4'd0);
        queue_request(KIND_RUN,    4'd15, 4'd15, 16'hFFFF, 4'd0);
        queue_request(KIND_RUN,    4'd0,  4'd0,  16'h0000, 4'd15);
        queue_request(KIND_ADD,    4'd15, 4'd0,  16'h8000, 4'd0);
        queue_request(KIND_RUN,    4'd0,  4'd0,  16'h0000, 4'd14);
        queue_request(KIND_REMOVE, 4'd15, 4'd0,  16'hFFFF, 4'd0);
        queue_request(KIND_REMOVE, 4'd15, 4'd0,  16'h0000, 4'd0);
        queue_request(KIND_RUN,    4'd0,  4'd0,  16'h0000, 4'd5);

        // mostly graph building with runs spread through; small weights force ties
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            roll   = $urandom_range(0, 99);
            from_v = VTX_FW'($urandom_range(0, VERTICES - 1));
            to_v   = VTX_FW'($urandom_range(0, VERTICES - 1));
            src    = VTX_FW'($urandom_range(0, VERTICES - 1));
            wt     = WT_W'($urandom_range(0, 65535));
            if (roll < 50) begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    wt = '0;
                else if (roll < 10)
                    wt = WT_W'($urandom_range(1, 4));
                else if (roll < 15)
                    wt = WT_W'($urandom_range(1, 255));
                queue_request(KIND_ADD, from_v, to_v, wt, src);
            end else if (roll < 67) begin
                pool.delete();
                foreach (planned_edge[f, t])
                    if (planned_edge[f][t])
                        pool.push_back(f * VERTICES + t);
                if (pool.size() != 0 && $urandom_range(0, 9) < 7) begin
                    slot   = pool[$urandom_range(0, pool.size() - 1)];
                    from_v = VTX_FW'(slot / VERTICES);
                    to_v   = VTX_FW'(slot % VERTICES);
                end
                queue_request(KIND_REMOVE, from_v, to_v, wt, src);
            end else if (roll < 72) begin
                queue_request(KIND_NOP, from_v, to_v, wt, src);
            end else begin
                queue_request(KIND_RUN, from_v, to_v, wt, src);
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (awaited_results.size() != 0)
            report_mismatch("results never arrived, count", 0, awaited_results.size());
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
design/ddsp_pkg.sv
design/ddsp_ram.sv
design/dense_dijkstra_shortest_paths.sv
test/dense_dijkstra_shortest_paths_tb.sv
